### hw/rtl/oblique_tree_leaf_search_unit_defines.svh
// ----------------------------------------------------------------------------
// oblique_tree_leaf_search_unit_defines
// Assertion helpers for the oblique tree leaf search unit.
// ----------------------------------------------------------------------------
`ifndef OBLIQUE_TREE_LEAF_SEARCH_UNIT_DEFINES_SVH
`define OBLIQUE_TREE_LEAF_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTLSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/otlsu_pkg.sv
// ----------------------------------------------------------------------------
// otlsu_pkg
// Shared types and constants of the oblique tree leaf search unit.
// ----------------------------------------------------------------------------
package otlsu_pkg;

    localparam int ID_W    = 10;  // node index and link width
    localparam int POS_W   = 6;   // coefficient / feature position, up to 64
    localparam int CADDR_W = 16;  // flat coefficient address, up to 1024 x 64
    localparam int LIM_W   = 17;  // compare width against node count limit
    localparam int ACC_W   = 71;  // exact sum of up to 64 Q32.32 products

    typedef enum logic [1:0] {
        OP_COEF = 2'd0,
        OP_THR  = 2'd1,
        OP_LINK = 2'd2,
        OP_FEAT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic               wr;     // write takes effect
        logic               walk;   // start a tree walk after this beat
        logic [ID_W-1:0]    node;
        logic [POS_W-1:0]   pos;
        logic [CADDR_W-1:0] caddr;
        logic [63:0]        data;   // coefficient, feature or threshold
        logic [ID_W-1:0]    left;
        logic [ID_W-1:0]    right;
    } t_cmd;

endpackage

### hw/rtl/oblique_tree_leaf_search_unit.sv
// ----------------------------------------------------------------------------
// oblique_tree_leaf_search_unit
// Oblique decision tree inference over a node table written by software.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken when start is high and busy is low. func selects a
//   coefficient, threshold or link write, or a feature load. A feature load
//   with query_last set starts a walk from node 0.
//   Beats pass a two-entry queue; busy is high only while the queue is full.
//   Writes and feature loads retire in order, only while no walk runs.
//   A walk visits one node at a time; for each node, one coefficient
//   memory read per cycle feeds a single 32x32 multiply-accumulate lane,
//   then the lane drains and the sum is compared. A register captures
//   the result, shown on o_done for exactly one cycle with o_leaf_index and
//   o_bad_link. The receiver cannot stall; results are never held.
//   Beats after a query wait in the queue until the walk finishes.
//   Reset (synchronous, active low) empties the queue and aborts any walk.
//   Table contents are not cleared; unwritten entries read as unknown.
// ----------------------------------------------------------------------------
module oblique_tree_leaf_search_unit
    import otlsu_pkg::*;
#(
    parameter int NODE_COUNT    = 1024,
    parameter int FEATURE_COUNT = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_func,
    input  logic [9:0]          i_node_index,
    input  logic [4:0]          i_position,
    input  logic signed [31:0]  i_coef_value,
    input  logic signed [63:0]  i_threshold_value,
    input  logic [9:0]          i_left_child,
    input  logic [9:0]          i_right_child,
    input  logic signed [31:0]  i_feature_value,
    input  logic                i_query_last,
    output logic                o_done,
    output logic [9:0]          o_leaf_index,
    output logic                o_bad_link
);

    logic push, pop, full, empty;
    t_cmd push_cmd, head_cmd;

    assign busy = full;

    // Front: range checks and flat coefficient address.
    otlsu_front #(
        .NODE_COUNT    (NODE_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_front (
        .i_start           (start),
        .i_full            (full),
        .i_func            (i_func),
        .i_node_index      (i_node_index),
        .i_position        (i_position),
        .i_coef_value      (i_coef_value),
        .i_threshold_value (i_threshold_value),
        .i_left_child      (i_left_child),
        .i_right_child     (i_right_child),
        .i_feature_value   (i_feature_value),
        .i_query_last      (i_query_last),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    // Decouples beat intake from the walk.
    otlsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Back: table memories and the tree walk.
    otlsu_back #(
        .NODE_COUNT    (NODE_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_leaf_index (o_leaf_index),
        .o_bad_link   (o_bad_link)
    );

endmodule

### hw/rtl/otlsu_front.sv
// ----------------------------------------------------------------------------
// otlsu_front
// Accepts input beats, range-checks them and builds a queue command.
// ----------------------------------------------------------------------------
module otlsu_front
    import otlsu_pkg::*;
#(
    parameter int NODE_COUNT    = 1024,
    parameter int FEATURE_COUNT = 18
) (
    input  logic                i_start,
    input  logic                i_full,
    input  logic [1:0]          i_func,
    input  logic [ID_W-1:0]     i_node_index,
    input  logic [4:0]          i_position,
    input  logic signed [31:0]  i_coef_value,
    input  logic signed [63:0]  i_threshold_value,
    input  logic [ID_W-1:0]     i_left_child,
    input  logic [ID_W-1:0]     i_right_child,
    input  logic signed [31:0]  i_feature_value,
    input  logic                i_query_last,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic node_ok;
    logic pos_ok;
    t_op  op;

    assign op      = t_op'(i_func);
    assign node_ok = {{(LIM_W-ID_W){1'b0}}, i_node_index} < LIM_W'(NODE_COUNT);
    assign pos_ok  = {{(LIM_W-5){1'b0}}, i_position} < LIM_W'(FEATURE_COUNT);
    assign o_push  = i_start && !i_full;

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = op;
        o_cmd.node  = i_node_index;
        o_cmd.pos   = {1'b0, i_position};
        o_cmd.caddr = CADDR_W'(CADDR_W'(i_node_index) * CADDR_W'(FEATURE_COUNT))
                      + CADDR_W'(i_position);
        o_cmd.left  = i_left_child;
        o_cmd.right = i_right_child;
        unique case (op)
            OP_COEF: begin
                o_cmd.wr   = node_ok && pos_ok;
                o_cmd.data = {{32{i_coef_value[31]}}, i_coef_value};
            end
            OP_THR: begin
                o_cmd.wr   = node_ok;
                o_cmd.data = i_threshold_value;
            end
            OP_LINK: begin
                o_cmd.wr = node_ok;
            end
            OP_FEAT: begin
                o_cmd.wr   = pos_ok;
                o_cmd.walk = i_query_last;
                o_cmd.data = {{32{i_feature_value[31]}}, i_feature_value};
            end
            default: o_cmd.wr = 1'b0;
        endcase
    end

endmodule

### hw/rtl/otlsu_queue.sv
// ----------------------------------------------------------------------------
// otlsu_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module otlsu_queue
    import otlsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = do_push ? !r_wptr : r_wptr;
        n_rptr = do_pop ? !r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### hw/rtl/otlsu_back.sv
// ----------------------------------------------------------------------------
// otlsu_back
// Executes table writes and walks the tree with one multiply-accumulate lane.
// ----------------------------------------------------------------------------
`include "oblique_tree_leaf_search_unit_defines.svh"

module otlsu_back
    import otlsu_pkg::*;
#(
    parameter int NODE_COUNT    = 1024,
    parameter int FEATURE_COUNT = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_cmd            i_cmd,
    output logic            o_pop,
    output logic            o_done,
    output logic [ID_W-1:0] o_leaf_index,
    output logic            o_bad_link
);

    localparam int NODE_DEPTH = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
    localparam int NA_W       = $clog2(NODE_DEPTH);
    localparam int COEF_DEPTH = NODE_DEPTH * FEATURE_COUNT;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int FA_W       = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int VIS_W      = $clog2(NODE_COUNT);

    logic signed [31:0] coef_mem [COEF_DEPTH];
    logic signed [63:0] thr_mem  [NODE_DEPTH];
    logic [ID_W-1:0]    left_mem [NODE_DEPTH];
    logic [ID_W-1:0]    right_mem[NODE_DEPTH];
    logic signed [31:0] feat_mem [FEATURE_COUNT];

    t_state r_state, n_state;

    logic [ID_W-1:0]     r_id;
    logic [VIS_W-1:0]    r_visits;
    logic [CA_W-1:0]     r_caddr;
    logic [FA_W-1:0]     r_k;
    logic                r_v1, r_v2;
    logic signed [31:0]  r_cdata, r_fdata;
    logic signed [63:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [63:0]  r_thr;
    logic [ID_W-1:0]     r_left, r_right;
    logic                r_done;
    logic [ID_W-1:0]     r_leaf;
    logic                r_bad;

    logic            issue;
    logic            last_issue;
    logic            below;
    logic [ID_W-1:0] next_id;
    logic            next_zero;
    logic            next_out;
    logic            visits_out;
    logic            walk_start;
    logic            decide;

    assign below      = r_acc < $signed({{(ACC_W-64){r_thr[63]}}, r_thr});
    assign next_id    = below ? r_right : r_left;
    assign next_zero  = next_id == '0;
    assign next_out   = {{(LIM_W-ID_W){1'b0}}, next_id} >= LIM_W'(NODE_COUNT);
    assign visits_out = r_visits == VIS_W'(NODE_COUNT - 1);
    assign last_issue = r_k == FA_W'(FEATURE_COUNT - 1);
    assign walk_start = o_pop && i_cmd.walk;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (walk_start) n_state = S_MAC;
            S_MAC:    if (last_issue) n_state = S_DRAIN;
            S_DRAIN:  if (!r_v1 && !r_v2) n_state = S_DECIDE;
            S_DECIDE: begin
                if (next_zero || next_out || visits_out) n_state = S_IDLE;
                else n_state = S_MAC;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = (r_state == S_IDLE) && !i_empty;
        issue  = r_state == S_MAC;
        decide = r_state == S_DECIDE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_done  <= decide && (next_zero || next_out || visits_out);
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.wr) begin
            unique case (i_cmd.op)
                OP_COEF: coef_mem[i_cmd.caddr[CA_W-1:0]] <= i_cmd.data[31:0];
                OP_THR:  thr_mem[i_cmd.node[NA_W-1:0]] <= i_cmd.data;
                OP_LINK: begin
                    left_mem[i_cmd.node[NA_W-1:0]]  <= i_cmd.left;
                    right_mem[i_cmd.node[NA_W-1:0]] <= i_cmd.right;
                end
                OP_FEAT: feat_mem[i_cmd.pos[FA_W-1:0]] <= i_cmd.data[31:0];
                default: ;
            endcase
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_cdata <= coef_mem[r_caddr];
        r_fdata <= feat_mem[r_k];
        r_thr   <= thr_mem[r_id[NA_W-1:0]];
        r_left  <= left_mem[r_id[NA_W-1:0]];
        r_right <= right_mem[r_id[NA_W-1:0]];
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= r_fdata * r_cdata;
        end
        if (walk_start) begin
            r_id     <= '0;
            r_visits <= '0;
            r_caddr  <= '0;
            r_k      <= '0;
        end else if (issue) begin
            r_caddr <= r_caddr + CA_W'(1);
            r_k     <= r_k + FA_W'(1);
        end else if (decide) begin
            r_id     <= next_id;
            r_visits <= r_visits + VIS_W'(1);
            r_caddr  <= CA_W'(CA_W'(next_id[NA_W-1:0]) * CA_W'(FEATURE_COUNT));
            r_k      <= '0;
        end
        // accumulate runs alongside issue; cleared per node
        if (walk_start || decide) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-64){r_prod[63]}}, r_prod};
        end
        if (decide) begin
            r_leaf <= r_id;
            r_bad  <= !next_zero;
        end
    end

    assign o_done       = r_done;
    assign o_leaf_index = r_leaf;
    assign o_bad_link   = r_bad;

    `OTLSU_ASSERT_NOW(a_done_idle, r_done, r_state == S_IDLE, "result outside idle")
    `OTLSU_ASSERT_NEXT(a_done_single, r_done, !r_done, "back-to-back results")
    `OTLSU_ASSERT_NOW(a_pipe_order, r_v2, $past(r_v1), "product stage without read")
    `OTLSU_ASSERT_NOW(a_no_pop_walk, r_state != S_IDLE, !o_pop, "queue pop during walk")

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oblique tree leaf search unit.
// Beats are driven on the falling edge: node table writes, feature loads and
// queries. A local model of the node table predicts the leaf reached by every
// query, and a scoreboard compares each strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import otlsu_pkg::*;

    // Holds the leaf predictions that are still waiting for the block.
    class leaf_scoreboard;
        typedef struct {
            logic [9:0] leaf;
            logic       bad;
        } t_leaf;

        t_leaf pending_q[$];
        int    mismatches;
        int    checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        function void note_query(logic [9:0] leaf, logic bad);
            t_leaf e;
            e.leaf = leaf;
            e.bad  = bad;
            pending_q = {pending_q, e};
        endfunction

        function void check_result(logic [9:0] leaf, logic bad);
            t_leaf e;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result leaf=%0d bad=%0b", leaf, bad);
                return;
            end
            e = pending_q.pop_front();
            if (e.leaf !== leaf || e.bad !== bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: leaf exp=%0d got=%0d, bad_link exp=%0b got=%0b",
                             e.leaf, leaf, e.bad, bad);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    localparam int NODES     = 1024;
    localparam int FEATS     = 18;
    localparam int N_BEATS   = 850;
    localparam int MAX_CYCLE = 80_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic [9:0]         i_node_index;
    logic [4:0]         i_position;
    logic signed [31:0] i_coef_value;
    logic signed [63:0] i_threshold_value;
    logic [9:0]         i_left_child;
    logic [9:0]         i_right_child;
    logic signed [31:0] i_feature_value;
    logic               i_query_last;
    logic               o_done;
    logic [9:0]         o_leaf_index;
    logic               o_bad_link;

    oblique_tree_leaf_search_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_node_index     (i_node_index),
        .i_position       (i_position),
        .i_coef_value     (i_coef_value),
        .i_threshold_value(i_threshold_value),
        .i_left_child     (i_left_child),
        .i_right_child    (i_right_child),
        .i_feature_value  (i_feature_value),
        .i_query_last     (i_query_last),
        .o_done           (o_done),
        .o_leaf_index     (o_leaf_index),
        .o_bad_link       (o_bad_link)
    );

    // Local copy of the node table and descriptor.
    logic signed [31:0] tbl_coef [NODES][FEATS];
    logic signed [63:0] tbl_thr  [NODES];
    logic [9:0]         tbl_left [NODES];
    logic [9:0]         tbl_right[NODES];
    logic signed [31:0] desc_feat[FEATS];

    // A node is "ready" once fully written and its links point only at
    // ready nodes of higher index (or 0); walks never touch anything else.
    bit ready_node[NODES];

    leaf_scoreboard sb;
    int  idle_pct;
    int  beats_sent;
    int  queries;
    int  bad_seen;
    longint cycles;

    always #4 i_clk = ~i_clk;

    // Exact dot product against the node threshold: 72 bits hold 18 full
    // Q32.32 products without overflow.
    function automatic bit dot_below_thr(int n);
        logic signed [71:0] acc;
        logic signed [63:0] prod;
        acc = '0;
        for (int i = 0; i < FEATS; i++) begin
            prod = desc_feat[i] * tbl_coef[n][i];
            acc += prod;
        end
        return acc < tbl_thr[n];
    endfunction

    // Update the table for one accepted beat; returns 1 when a walk starts.
    function automatic bit apply_beat(output logic [9:0] leaf, output logic bad);
        int id, nxt, visits;
        leaf = '0;
        bad  = 1'b0;
        case (t_op'(i_func))
            OP_COEF: if (i_position < FEATS)
                tbl_coef[i_node_index][i_position] = i_coef_value;
            OP_THR:  tbl_thr[i_node_index] = i_threshold_value;
            OP_LINK: begin
                tbl_left[i_node_index]  = i_left_child;
                tbl_right[i_node_index] = i_right_child;
            end
            OP_FEAT: begin
                if (i_position < FEATS)
                    desc_feat[i_position] = i_feature_value;
                if (i_query_last) begin
                    id = 0;
                    visits = 0;
                    forever begin
                        leaf = id[9:0];
                        visits++;
                        nxt = dot_below_thr(id) ? tbl_right[id] : tbl_left[id];
                        if (nxt == 0)
                            break;
                        if (nxt >= NODES || visits >= NODES) begin
                            bad = 1'b1;
                            break;
                        end
                        id = nxt;
                    end
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // Monitor: results are checked before the new beat is predicted, so
    // the queue order stays right when both land on one edge.
    always @(posedge i_clk) begin
        logic [9:0] leaf;
        logic       bad;
        if (i_rst_n) begin
            cycles++;
            if (o_done)
                sb.check_result(o_leaf_index, o_bad_link);
            if (start && !busy && apply_beat(leaf, bad)) begin
                sb.note_query(leaf, bad);
                queries++;
                if (bad)
                    bad_seen++;
            end
            if (cycles > MAX_CYCLE) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 9))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return 64'($signed($urandom_range(0, 4000)) - 2000) <<< 32;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random ready node above n, or 0 to end the walk there.
    function automatic logic [9:0] pick_child(int n);
        int cand[$];
        for (int k = n + 1; k < NODES; k++)
            if (ready_node[k])
                cand = {cand, k};
        if (cand.size() == 0 || $urandom_range(0, 3) == 0)
            return '0;
        return 10'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    // One beat; fields the operation does not use carry random noise.
    // start stays high after the accepting edge until the next call or a
    // drain lowers it at the following falling edge.
    task automatic send_beat(t_op op, logic [9:0] node, logic [4:0] pos,
                             logic [31:0] val32, logic [63:0] val64,
                             logic [9:0] lft, logic [9:0] rgt, logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start             = 1'b1;
        i_func            = op;
        i_node_index      = node;
        i_position        = pos;
        i_coef_value      = (op == OP_COEF) ? val32 : $urandom;
        i_feature_value   = (op == OP_FEAT) ? val32 : $urandom;
        i_threshold_value = (op == OP_THR)  ? val64 : {$urandom, $urandom};
        i_left_child      = (op == OP_LINK) ? lft : 10'($urandom);
        i_right_child     = (op == OP_LINK) ? rgt : 10'($urandom);
        i_query_last      = last;
        do
            @(posedge i_clk);
        while (busy);
        beats_sent++;
    endtask

    task automatic init_node(int n, logic [9:0] lft, logic [9:0] rgt);
        for (int p = 0; p < FEATS; p++)
            send_beat(OP_COEF, 10'(n), 5'(p), rnd32(), '0, '0, '0,
                      1'($urandom_range(0, 1)));
        send_beat(OP_THR, 10'(n), 5'($urandom), '0, rnd64(), '0, '0, 1'b0);
        send_beat(OP_LINK, 10'(n), 5'($urandom), '0, '0, lft, rgt, 1'b0);
        ready_node[n] = 1'b1;
    endtask

    task automatic query(logic [4:0] pos, logic [31:0] val);
        send_beat(OP_FEAT, 10'($urandom), pos, val, '0, '0, '0, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_beat();
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_beat(OP_FEAT, 10'($urandom),
                      ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17)),
                      rnd32(), '0, '0, '0, $urandom_range(0, 9) < 4);
        end else if (r < 55) begin
            send_beat(OP_COEF, 10'($urandom), 5'($urandom), rnd32(), '0, '0, '0,
                      1'($urandom_range(0, 1)));
        end else if (r < 65) begin
            send_beat(OP_THR, 10'($urandom), 5'($urandom), '0, rnd64(), '0, '0,
                      1'($urandom_range(0, 1)));
        end else if (r < 92) begin
            // Relink: a ready node keeps its forward-only links.
            n = $urandom_range(0, 1023);
            if ($urandom_range(0, 1))
                for (int k = 0; k < NODES; k++)
                    if (ready_node[(n + k) % NODES]) begin
                        n = (n + k) % NODES;
                        break;
                    end
            send_beat(OP_LINK, 10'(n), 5'($urandom), '0, '0, pick_child(n), pick_child(n),
                      1'($urandom_range(0, 1)));
        end else begin
            n = $urandom_range(2, 1022);
            init_node(n, pick_child(n), pick_child(n));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = OP_COEF;
        i_node_index = '0;
        i_position = '0;
        i_coef_value = '0;
        i_threshold_value = '0;
        i_left_child = '0;
        i_right_child = '0;
        i_feature_value = '0;
        i_query_last = 1'b0;
        sb = new();
        idle_pct = 37;
        beats_sent = 0;
        queries = 0;
        bad_seen = 0;
        cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Small tree, children first so every link lands on a ready node.
        init_node(1023, '0, '0);
        init_node(700, 10'd1023, '0);
        init_node(341, 10'd700, 10'd1023);
        init_node(1, 10'd341, 10'd700);
        init_node(0, 10'd1, 10'd341);

        // Full descriptor with extreme and random features, last one starts a walk.
        for (int p = 0; p < FEATS; p++)
            send_beat(OP_FEAT, '0, 5'(p),
                      (p % 3 == 0) ? 32'h8000_0000 : (p % 3 == 1) ? 32'h7FFF_FFFF : rnd32(),
                      '0, '0, '0, p == FEATS - 1);
        // query_last on a write is ignored; on an out-of-range feature it
        // still walks.
        send_beat(OP_COEF, 10'd1, 5'd31, 32'h1234_5678, '0, '0, '0, 1'b1);
        query(5'd31, 32'hFFFF_FFFF);
        send_beat(OP_THR, 10'd0, '0, '0, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
        query(5'd0, 32'h0000_0000);
        send_beat(OP_THR, 10'd0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, 1'b0);
        query(5'd2, 32'h0001_0000);

        // Cyclic links on node 1: a walk that reaches it runs out of visits and flags a bad link.
        wait_drained();
        send_beat(OP_LINK, 10'd1, '0, '0, '0, 10'd1, 10'd1, 1'b0);
        query(5'd3, rnd32());
        send_beat(OP_LINK, 10'd1, '0, '0, '0, 10'd341, 10'd700, 1'b0);
        wait_drained();

        // Random part in three idle phases, drained where the beat count lands on a boundary.
        while (beats_sent < N_BEATS) begin
            if (beats_sent < N_BEATS / 3)
                idle_pct = 37;
            else if (beats_sent < 2 * N_BEATS / 3)
                idle_pct = 52;
            else
                idle_pct = 0;
            random_beat();
            if (beats_sent % (N_BEATS / 3) < 2 && beats_sent > 200)
                wait_drained();
        end

        wait_drained();
        $display("Sent %0d beats, %0d queries, %0d walks flagged bad_link", beats_sent,
                 queries, bad_seen);
        $display("Checked %0d results over %0d cycles", sb.checked, cycles);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
